/* rtl/cos_pkg.sv */
package cos_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam logic [7:0] CH_P_UP = 8'h50;
  localparam logic [7:0] CH_P_LO = 8'h70;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_T_LO = 8'h74;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_LOW  = 2'd1;
  localparam logic [1:0] CLASS_MID  = 2'd2;
  localparam logic [1:0] CLASS_HIGH = 2'd3;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  lead_char;
    logic [15:0] item_tag;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_tag;
    logic [1:0]  out_class;
    logic [3:0]  fill_level;
    logic        now_empty;
    logic        now_full;
  } out_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [1:0]  cls;
  } entry_t;

  typedef struct packed {
    logic push;
    logic occ;
    logic at_count;
    logic lt_below;
  } cell_ctrl_t;

  function automatic logic [1:0] class_of(input logic [7:0] ch);
    logic [1:0] c;
    if (ch == CH_P_UP || ch == CH_P_LO) begin
      c = CLASS_HIGH;
    end else if (ch == CH_T_UP || ch == CH_T_LO) begin
      c = CLASS_MID;
    end else begin
      c = CLASS_LOW;
    end
    return c;
  endfunction

endpackage

/* rtl/cos_cell.sv */
module cos_cell import cos_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     below_i,
  output entry_t     entry_o,
  output logic       lt_o
);

  entry_t entry_q, entry_d;

  assign lt_o = ctrl_i.occ && (entry_q.cls < new_i.cls);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (ctrl_i.lt_below) begin
        entry_d = below_i;
      end else if (lt_o || ctrl_i.at_count) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* rtl/class_ordered_stack.sv */
// Result: registered; it appears on out_data_o in the cycle after the input transfer.
// Throughput: one operation per cycle while the output is not stalled; a push shifts every displaced entry
// one cell up in the same cycle, so no operation waits on another.
// Reset: asynchronous, active low; clears the fill count and the output
// valid. Entry cells are not reset and are only read below the fill count.
module class_ordered_stack import cos_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  entry_t     entries [DEPTH];
  logic       lts     [DEPTH];
  cell_ctrl_t ctrls   [DEPTH];
  entry_t     new_entry;
  entry_t     top_entry;
  logic [IDX_W-1:0] top_idx;
  logic       accept;
  logic       is_full;
  logic       is_empty;
  logic       do_push;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CNT_W'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign do_push    = accept && (in_data_i.func == FUNC_PUSH) && !is_full;

  assign new_entry.tag = in_data_i.item_tag;
  assign new_entry.cls = class_of(in_data_i.lead_char);

  assign top_idx   = IDX_W'(count_q - CNT_W'(1));
  assign top_entry = entries[top_idx];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrls[i].push     = do_push;
    assign ctrls[i].occ      = (CNT_W'(i) < count_q);
    assign ctrls[i].at_count = (count_q == CNT_W'(i));
    if (i == 0) begin : g_bottom
      assign ctrls[i].lt_below = 1'b0;
      cos_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrls[i]),
        .new_i   (new_entry),
        .below_i (new_entry),
        .entry_o (entries[i]),
        .lt_o    (lts[i])
      );
    end else begin : g_upper
      assign ctrls[i].lt_below = lts[i-1];
      cos_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrls[i]),
        .new_i   (new_entry),
        .below_i (entries[i-1]),
        .entry_o (entries[i]),
        .lt_o    (lts[i])
      );
    end
  end

  always_comb begin
    count_d = count_q;
    out_d   = out_q;
    if (accept) begin
      out_d.status    = STATUS_OK;
      out_d.out_tag   = '0;
      out_d.out_class = CLASS_NONE;
      case (in_data_i.func)
        FUNC_PUSH: begin
          if (is_full) begin
            out_d.status = STATUS_FULL;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        FUNC_POP, FUNC_PEEK: begin
          if (is_empty) begin
            out_d.status = STATUS_EMPTY;
          end else begin
            out_d.out_tag   = top_entry.tag;
            out_d.out_class = top_entry.cls;
            if (in_data_i.func == FUNC_POP) begin
              count_d = count_q - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
      out_d.fill_level = 4'(count_d);
      out_d.now_empty  = (count_d == '0);
      out_d.now_full   = (count_d == CNT_W'(DEPTH));
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* verif/tb_class_ordered_stack.sv */
module tb_class_ordered_stack;
  import cos_pkg::*;

  localparam logic [1:0] FUNC_NOP    = 2'd3;
  localparam int unsigned RANDOM_OPS  = 1750;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    in_t op;
    bit  settle;
  } queued_op_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  queued_op_t  pending_ops[$];
  out_t        due_results[$];
  entry_t      stk[DEPTH];
  int unsigned stk_fill = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt = 0;
  logic        in_fire = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned tx_quiet = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_quiet = 0;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold = 700;

  class_ordered_stack u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int unsigned next_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Ordered insert on push: lower classes move up, new entry goes beneath them; pop and peek read the top.
  function automatic out_t apply_stack_op(in_t op);
    out_t        r;
    logic [1:0]  c;
    int unsigned pos;
    r = '0;
    r.status = STATUS_OK;
    case (op.lead_char)
      CH_P_UP, CH_P_LO: c = CLASS_HIGH;
      CH_T_UP, CH_T_LO: c = CLASS_MID;
      default:          c = CLASS_LOW;
    endcase
    case (op.func)
      FUNC_PUSH: begin
        if (stk_fill >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          pos = stk_fill;
          while (pos > 0 && stk[pos-1].cls < c) begin
            stk[pos] = stk[pos-1];
            pos--;
          end
          stk[pos].tag = op.item_tag;
          stk[pos].cls = c;
          stk_fill++;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (stk_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.out_tag   = stk[stk_fill-1].tag;
          r.out_class = stk[stk_fill-1].cls;
          if (op.func == FUNC_POP) stk_fill--;
        end
      end
      default: ;
    endcase
    r.fill_level = 4'(stk_fill);
    r.now_empty  = (stk_fill == 0);
    r.now_full   = (stk_fill == DEPTH);
    return r;
  endfunction

  task automatic add_item(logic [1:0] f, logic [7:0] ch, logic [15:0] tag, bit settle);
    queued_op_t q;
    q.op     = in_t'({f, ch, tag});
    q.settle = settle;
    pending_ops.push_back(q);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) begin
      $display("mismatch on %s at result %0d: got %0h, want %0h", what, result_cnt, got, want);
    end
  endtask

  // Sender: hold until transfer, then idle or offer the next queued operation.
  always @(negedge clk_i) begin
    queued_op_t nxt;
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (tx_gap != 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].settle && due_results.size() != 0)) begin
        nxt = pending_ops.pop_front();
        in_data_i  <= nxt.op;
        in_valid_i <= 1'b1;
        tx_gap = next_gap(tx_quiet);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus long hold-offs while the sender is busy.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_cycle >= next_hold && in_valid_i) begin
        hold_left = HOLD_CYCLES;
        next_hold = (next_hold == 700) ? 5000 : 32'hFFFF_FFFF;
        out_ready_i <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        rx_gap = next_gap(rx_quiet);
      end
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      in_fire <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        result_cnt++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.out_tag, 16'h0);
        end else begin
          want = due_results.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch("status", 16'(out_data_o.status), 16'(want.status));
          if (out_data_o.out_tag !== want.out_tag)
            report_mismatch("out_tag", out_data_o.out_tag, want.out_tag);
          if (out_data_o.out_class !== want.out_class)
            report_mismatch("out_class", 16'(out_data_o.out_class), 16'(want.out_class));
          if (out_data_o.fill_level !== want.fill_level)
            report_mismatch("fill_level", 16'(out_data_o.fill_level), 16'(want.fill_level));
          if (out_data_o.now_empty !== want.now_empty)
            report_mismatch("now_empty", 16'(out_data_o.now_empty), 16'(want.now_empty));
          if (out_data_o.now_full !== want.now_full)
            report_mismatch("now_full", 16'(out_data_o.now_full), 16'(want.now_full));
        end
      end
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(apply_stack_op(in_data_i));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned n_random;
    int unsigned mode;
    int unsigned burst;
    int unsigned push_pct;
    int unsigned r;
    int unsigned k;
    logic [1:0]  f;
    logic [7:0]  ch;
    bit          settle;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;

    // empty store, unused selector, fill with all classes, full, then drain
    add_item(FUNC_POP,  8'h00,   16'h0000, 1'b0);
    add_item(FUNC_PEEK, 8'hFF,   16'hFFFF, 1'b0);
    add_item(FUNC_NOP,  8'hFF,   16'hFFFF, 1'b0);
    add_item(FUNC_PUSH, CH_P_UP, 16'hFFFF, 1'b0);
    add_item(FUNC_PUSH, CH_T_LO, 16'h1234, 1'b0);
    add_item(FUNC_PUSH, CH_P_LO, 16'h0001, 1'b0);
    add_item(FUNC_PUSH, CH_T_UP, 16'h8000, 1'b0);
    add_item(FUNC_PUSH, 8'h00,   16'h0000, 1'b0);
    add_item(FUNC_PUSH, 8'hFF,   16'hFFFF, 1'b0);
    add_item(FUNC_PUSH, 8'h51,   16'hAAAA, 1'b0);
    add_item(FUNC_PUSH, 8'h6F,   16'h5555, 1'b0);
    add_item(FUNC_PUSH, CH_P_LO, 16'h7E7E, 1'b0);
    add_item(FUNC_NOP,  8'h00,   16'h0000, 1'b0);
    add_item(FUNC_PEEK, 8'h00,   16'h0000, 1'b0);
    repeat (8) add_item(FUNC_POP, 8'h00, 16'h0000, 1'b0);
    add_item(FUNC_POP,  8'hFF,   16'hFFFF, 1'b0);

    n_random = 0;
    while (n_random < RANDOM_OPS) begin
      mode  = $urandom_range(0, 2);
      burst = $urandom_range(10, 60);
      push_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 50;
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          f = FUNC_NOP;
        end else if (r < push_pct) begin
          f = FUNC_PUSH;
        end else if ($urandom_range(0, 2) == 0) begin
          f = FUNC_PEEK;
        end else begin
          f = FUNC_POP;
        end
        case ($urandom_range(0, 3))
          0:       ch = CH_P_UP;
          1:       ch = CH_P_LO;
          2:       ch = CH_T_UP;
          default: ch = CH_T_LO;
        endcase
        k = $urandom_range(0, 9);
        if (k >= 6) begin
          ch = 8'($urandom_range(0, 255));
        end else if (k >= 4) begin
          ch = ch ^ (8'h01 << $urandom_range(0, 7));
        end
        settle = (n_random == 0) || ($urandom_range(0, 199) == 0);
        add_item(f, ch, 16'($urandom_range(0, 65535)), settle);
        n_random++;
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cos_pkg.sv
rtl/cos_cell.sv
rtl/class_ordered_stack.sv
verif/tb_class_ordered_stack.sv
